FILE: src/prle_pkg.sv
// Shared constants, codes and types for the positional ring list engine.
package prle_pkg;

  localparam int CAPACITY = 16;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  // wide enough for position and length + 1 without wrap
  localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT,
    OP_INS_BACK,
    OP_INS_POS,
    OP_DEL_FRONT,
    OP_DEL_BACK,
    OP_DEL_POS,
    OP_DUMP,
    OP_COUNT
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_EMPTY,
    ST_BADPOS,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_WV,
    S_DRD,
    S_DEMIT,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [DATA_W-1:0] element;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } result_t;

endpackage

FILE: src/prle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/prle_ctrl.sv
// Sequencer: decodes a transaction, steps the shared index over the store, emits results.
module prle_ctrl (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  input  logic [prle_pkg::OP_W-1:0]                 in_opcode,
  input  logic [prle_pkg::POS_W-1:0]                in_position,
  input  logic signed [prle_pkg::DATA_W-1:0]        in_value,
  output logic                                      in_stall,
  output prle_pkg::result_t                         res,
  input  logic                                      res_ready,
  output logic                                      ram_we,
  output logic [prle_pkg::ADDR_W-1:0]               ram_waddr,
  output logic [prle_pkg::DATA_W-1:0]               ram_wdata,
  output logic [prle_pkg::ADDR_W-1:0]               ram_raddr,
  input  logic [prle_pkg::DATA_W-1:0]               ram_rdata
);
  import prle_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  tgt_r, tgt_nxt;
  logic              ins_r, ins_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;

  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  sel_pos;
  logic [LEN_W-1:0]  idx_dn;
  logic [LEN_W-1:0]  idx_up;
  op_t               op;

  assign len_ext = CMP_W'(len_r);
  assign idx_ext = CMP_W'(idx_r);
  assign pos_ext = CMP_W'(in_position);
  assign idx_dn  = idx_r - LEN_W'(1);
  assign idx_up  = idx_r + LEN_W'(1);
  assign op      = op_t'(in_opcode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    tgt_r    <= tgt_nxt;
    ins_r    <= ins_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    tgt_nxt     = tgt_r;
    ins_nxt     = ins_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    sel_pos     = '0;
    in_stall    = (state_r != S_IDLE);
    res         = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r[ADDR_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              unique case (op)
                OP_INS_FRONT: sel_pos = CMP_W'(1);
                OP_INS_BACK:  sel_pos = len_ext + CMP_W'(1);
                default:      sel_pos = pos_ext;
              endcase
              if (sel_pos == '0 || sel_pos > len_ext + CMP_W'(1)) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else if (len_ext >= CMP_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                status_nxt = ST_OK;
                tgt_nxt    = LEN_W'(sel_pos - CMP_W'(1));
                idx_nxt    = len_r;
                ins_nxt    = 1'b1;
                val_nxt    = in_value;
                // slots from the target up move one place toward the back
                state_nxt  = (len_ext > sel_pos - CMP_W'(1)) ? S_RD : S_WV;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
              unique case (op)
                OP_DEL_FRONT: sel_pos = CMP_W'(1);
                OP_DEL_BACK:  sel_pos = len_ext;
                default:      sel_pos = pos_ext;
              endcase
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else if (sel_pos == '0 || sel_pos > len_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_RESP;
              end else begin
                status_nxt = ST_OK;
                idx_nxt    = LEN_W'(sel_pos - CMP_W'(1));
                ins_nxt    = 1'b0;
                if (sel_pos < len_ext) begin
                  state_nxt = S_RD;
                end else begin
                  len_nxt   = len_r - LEN_W'(1);
                  state_nxt = S_RESP;
                end
              end
            end
            OP_DUMP: begin
              if (len_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                status_nxt = ST_OK;
                idx_nxt    = '0;
                state_nxt  = S_DRD;
              end
            end
            OP_COUNT: begin
              status_nxt = ST_OK;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end
      S_RD: begin
        ram_raddr = ins_r ? idx_dn[ADDR_W-1:0] : idx_up[ADDR_W-1:0];
        state_nxt = S_WR;
      end
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (ins_r) begin
          idx_nxt   = idx_dn;
          state_nxt = (idx_dn > tgt_r) ? S_RD : S_WV;
        end else begin
          idx_nxt = idx_up;
          if (idx_ext + CMP_W'(2) < len_ext) begin
            state_nxt = S_RD;
          end else begin
            len_nxt   = len_r - LEN_W'(1);
            state_nxt = S_RESP;
          end
        end
      end
      S_WV: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r[ADDR_W-1:0];
        ram_wdata = val_r;
        len_nxt   = len_r + LEN_W'(1);
        state_nxt = S_RESP;
      end
      S_DRD: begin
        state_nxt = S_DEMIT;
      end
      S_DEMIT: begin
        // read address still on idx, so the read data holds while stalled
        res.valid   = 1'b1;
        res.status  = ST_OK;
        res.element = ram_rdata;
        res.count   = COUNT_W'(len_r);
        res.last    = (idx_ext + CMP_W'(1) == len_ext);
        if (res_ready) begin
          if (idx_ext + CMP_W'(1) == len_ext) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_up;
            state_nxt = S_DRD;
          end
        end
      end
      S_RESP: begin
        res.valid   = 1'b1;
        res.status  = status_r;
        res.element = '0;
        res.count   = COUNT_W'(len_r);
        res.last    = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/positional_ring_list_engine_unit.sv
// Top level: bounded ordered list engine with a registered result stage.
//
//   channel | ports                                  | dir
//   --------+----------------------------------------+-----
//   in      | in_valid in_stall in_opcode            | in
//           | in_position in_value                   |
//   out     | out_valid out_stall out_status         | out
//           | out_element out_count out_last         |
//
// One transaction at a time; in_stall is high while an operation runs.
// Insert and delete move each shifted element by a read then a write through the single
// RAM port pair; an insert then writes the new value into its slot.
// Dump reads each element in turn (registered RAM read); count and rejects go straight to the response.
// Synchronous active-low reset empties the list; store contents are not cleared.
// out_stall holds the result register; the sequencer waits on it.
module positional_ring_list_engine_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [prle_pkg::OP_W-1:0]           in_opcode,
  input  logic [prle_pkg::POS_W-1:0]          in_position,
  input  logic signed [prle_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [prle_pkg::STATUS_W-1:0]       out_status,
  output logic signed [prle_pkg::DATA_W-1:0]  out_element,
  output logic [prle_pkg::COUNT_W-1:0]        out_count,
  output logic                                out_last
);
  import prle_pkg::*;

  result_t           res;
  logic              res_ready;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_last_r;

  assign res_ready = !out_valid_r || !out_stall;

  prle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_value    (in_value),
    .in_stall    (in_stall),
    .res         (res),
    .res_ready   (res_ready),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  prle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_status_r  <= res.status;
      out_element_r <= res.element;
      out_count_r   <= res.count;
      out_last_r    <= res.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

endmodule

FILE: dv/positional_ring_list_engine_unit_tb.sv
// Self-checking testbench for the positional ring list engine: list model, scoreboard, traffic.
module positional_ring_list_engine_unit_tb;
  import prle_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] element;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } list_result_t;

  // Mirrors the list contents and queues the results each operation should produce.
  class list_scoreboard;
    logic signed [DATA_W-1:0] elems[$];
    list_result_t             expected_q[$];
    int mismatches;
    int checked;
    int accepted;
    int full_refusals;
    int bad_positions;
    int empty_hits;

    function int length();
      return elems.size();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void push_expect(status_t st, logic signed [DATA_W-1:0] el, logic lst);
      list_result_t r;
      r.status  = st;
      r.element = el;
      r.count   = COUNT_W'(elems.size());
      r.last    = lst;
      expected_q.push_back(r);
      case (st)
        ST_FULL:   full_refusals++;
        ST_BADPOS: bad_positions++;
        ST_EMPTY:  empty_hits++;
        default: ;
      endcase
    endfunction

    function void note_input(op_t op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
      int n;
      int p;
      status_t st;
      n  = elems.size();
      p  = pos;
      st = ST_OK;
      accepted++;
      case (op)
        OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
          if (op == OP_INS_FRONT) p = 1;
          else if (op == OP_INS_BACK) p = n + 1;
          // position is checked before capacity
          if (p < 1 || p > n + 1) st = ST_BADPOS;
          else if (n >= CAPACITY) st = ST_FULL;
          else elems.insert(p - 1, val);
        end
        OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
          if (op == OP_DEL_FRONT) p = 1;
          else if (op == OP_DEL_BACK) p = n;
          if (n == 0) st = ST_EMPTY;
          else if (p < 1 || p > n) st = ST_BADPOS;
          else elems.delete(p - 1);
        end
        OP_DUMP: begin
          if (n == 0) push_expect(ST_EMPTY, '0, 1'b1);
          else foreach (elems[i]) push_expect(ST_OK, elems[i], i == n - 1);
          return;
        end
        default: ;
      endcase
      push_expect(st, '0, 1'b1);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic signed [DATA_W-1:0] el,
                               logic [COUNT_W-1:0] cnt, logic lst);
      list_result_t e;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: status %0d element %0d count %0d last %0d",
                         st, el, cnt, lst));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status || el !== e.element || cnt !== e.count || lst !== e.last)
        report($sformatf({"result %0d: expected status %0d element %0d count %0d last %0d,",
                          " got status %0d element %0d count %0d last %0d"},
                         checked, e.status, e.element, e.count, e.last, st, el, cnt, lst));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_opcode;
  logic [POS_W-1:0]           in_position;
  logic signed [DATA_W-1:0]   in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [STATUS_W-1:0]        out_status;
  logic signed [DATA_W-1:0]   out_element;
  logic [COUNT_W-1:0]         out_count;
  logic                       out_last;

  list_scoreboard sb;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic hold_on;
  event hold_start;

  positional_ring_list_engine_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_element (out_element),
    .out_count   (out_count),
    .out_last    (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    hold_on = 1'b0;
    forever begin
      @(hold_start);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_element, out_count, out_last);
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // Starts and ends at a falling edge; in_valid stays high into the next transaction.
  task automatic send_item(op_t op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, pos, val);
    @(negedge clk);
  endtask

  task automatic run_random(int items, int ins_pct, int del_pct);
    int r;
    int n;
    op_t op;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] val;
    for (int k = 0; k < items; k++) begin
      n = sb.length();
      r = $urandom_range(99);
      if (r < ins_pct) op = op_t'(OP_INS_FRONT + $urandom_range(2));
      else if (r < ins_pct + del_pct) op = op_t'(OP_DEL_FRONT + $urandom_range(2));
      else op = ($urandom_range(3) == 0) ? OP_COUNT : OP_DUMP;
      // mostly legal positions, sometimes anything the field holds
      if ($urandom_range(4) == 0) pos = POS_W'($urandom);
      else if (op == OP_DEL_POS) pos = POS_W'($urandom_range(n > 0 ? n : 1, 1));
      else pos = POS_W'($urandom_range(n + 1, 1));
      val = $urandom;
      case ($urandom_range(9))
        0: val = 32'sh8000_0000;
        1: val = 32'sh7fff_ffff;
        default: ;
      endcase
      send_item(op, pos, val);
    end
  endtask

  initial begin
    sb = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = '0;
    in_position    = '0;
    in_value       = '0;
    out_stall      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty list corners, edge values, every operation
    send_item(OP_COUNT, 5'd0, '0);
    send_item(OP_DUMP, 5'd0, '0);
    send_item(OP_DEL_FRONT, 5'd0, '0);
    send_item(OP_DEL_BACK, 5'd0, '0);
    send_item(OP_DEL_POS, 5'd1, '0);
    send_item(OP_INS_POS, 5'd0, 32'sd5);
    send_item(OP_INS_POS, 5'd2, 32'sd6);
    send_item(OP_INS_POS, 5'd1, 32'sh7fff_ffff);
    send_item(OP_INS_FRONT, 5'd31, 32'sh8000_0000);
    send_item(OP_INS_BACK, 5'd0, -32'sd1);
    send_item(OP_INS_POS, 5'd4, 32'sd0);
    send_item(OP_INS_POS, 5'd2, 32'sh5555_5555);
    send_item(OP_INS_POS, 5'd7, 32'shaaaa_aaaa);
    send_item(OP_DUMP, 5'd0, '0);
    send_item(OP_DEL_POS, 5'd0, '0);
    send_item(OP_DEL_POS, 5'd6, '0);
    send_item(OP_DEL_POS, 5'd31, '0);
    send_item(OP_DEL_POS, 5'd3, '0);
    send_item(OP_DEL_FRONT, 5'd0, '0);
    send_item(OP_DEL_BACK, 5'd0, '0);
    send_item(OP_COUNT, 5'd0, '0);
    send_item(OP_DUMP, 5'd0, '0);

    // insert-heavy, runs the list into full
    run_random(30, 85, 5);

    // long receiver hold-off while dumps keep coming
    -> hold_start;
    repeat (5) send_item(OP_DUMP, 5'd0, '0);

    send_idle_pct = 45;
    run_random(12, 35, 40);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    run_random(12, 50, 25);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_random(12, 25, 55);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(7, 40, 30);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d results checked, %0d mismatches",
             sb.accepted, sb.checked, sb.mismatches);
    $display("refused on full %0d, rejected positions %0d, empty-list responses %0d",
             sb.full_refusals, sb.bad_positions, sb.empty_hits);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
